@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk with reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define CHK_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A consequent that must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ilwe_pkg.sv @@
// ----------------------------------------------------------------------------
// ilwe_pkg
// Types and constants shared by the indexed list cells and the top level.
// ----------------------------------------------------------------------------
package ilwe_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 6;
    localparam int CNT_W     = 7;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_DROP   = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_WRITE  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                      cmd;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  word_in;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0]  word_out;
        t_status                   status;
        logic [CNT_W-1:0]          count;
    } t_out_word;

    // Qualified load controls broadcast to every cell of the row.
    typedef struct packed {
        logic                      app;
        logic                      wr;
        logic                      ers;
        logic signed [WORD_W-1:0]  word;
    } t_cell_ctrl;

endpackage

@@ hdl/ilwe_cell.sv @@
// ----------------------------------------------------------------------------
// ilwe_cell
// One list entry: loads an appended or written word, or its upper neighbor's
// word during an erase, and offers its word when the position selects it.
// ----------------------------------------------------------------------------
module ilwe_cell
    import ilwe_pkg::*;
#(
    parameter int IDX  = 0,
    parameter int CMPW = 7
) (
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic [CMPW-1:0]           i_count,
    input  logic [CMPW-1:0]           i_pos,
    input  logic signed [WORD_W-1:0]  i_next_word,
    output logic signed [WORD_W-1:0]  o_word,
    output logic signed [WORD_W-1:0]  o_rd_word
);

    localparam logic [CMPW-1:0] IDX_V  = CMPW'(IDX);
    localparam logic [CMPW-1:0] IDX_N  = CMPW'(IDX + 1);

    logic signed [WORD_W-1:0] r_word;
    logic                     sel;
    logic                     ld_new;
    logic                     ld_shift;

    assign sel      = (IDX_V == i_pos);
    assign ld_new   = (i_ctrl.app && (IDX_V == i_count)) || (i_ctrl.wr && sel);
    // Every live entry at or above the erased one, except the last, takes the word above it.
    assign ld_shift = i_ctrl.ers && (IDX_V >= i_pos) && (IDX_N < i_count);

    always_ff @(posedge i_clk) begin
        if (ld_new) begin
            r_word <= i_ctrl.word;
        end else if (ld_shift) begin
            r_word <= i_next_word;
        end
    end

    // The held word goes to the lower neighbor; the selected word goes to the read bus.
    assign o_word    = r_word;
    assign o_rd_word = sel ? r_word : '0;

endmodule

@@ hdl/indexed_list_with_erase_top.sv @@
// ----------------------------------------------------------------------------
// indexed_list_with_erase_top
// Packed list of up to DEPTH signed words held in a row of cells, with
// append, drop last, erase with shift down, read and write by index.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   i_in  (t_in_word)
// result    out        o_strobe for one cycle o_out (t_out_word)
//
// A command word is taken at every clock edge where start is high; busy stays
// low because each command finishes in the edge that accepts it.
// The result word appears on o_out the cycle after, marked by o_strobe.
// All cells load, write or shift down together in that one edge, so an erase
// takes no longer than a read.
// Reset clears the count and the strobe; the cell contents are not reset.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_list_with_erase_top
    import ilwe_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output logic      o_strobe,
    output t_out_word o_out
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_strobe;
    t_out_word                 r_out;
    t_out_word                 n_out;

    logic                      accept;
    logic                      full;
    logic                      hit;
    logic [CMPW-1:0]           pos_x;
    logic [CMPW-1:0]           cnt_x;
    t_cell_ctrl                ctrl;
    logic signed [WORD_W-1:0]  rd_word [DEPTH];
    logic signed [WORD_W-1:0]  cell_word [DEPTH];
    logic signed [WORD_W-1:0]  nxt_word [DEPTH];
    logic signed [WORD_W-1:0]  rd_or;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pos_x  = CMPW'(i_in.position);
    assign cnt_x  = CMPW'(r_count);
    assign full   = (r_count == CW'(DEPTH));
    assign hit    = (pos_x < cnt_x);

    assign ctrl.app  = accept && (i_in.cmd == CMD_APPEND) && !full;
    assign ctrl.wr   = accept && (i_in.cmd == CMD_WRITE) && hit;
    assign ctrl.ers  = accept && (i_in.cmd == CMD_ERASE) && hit;
    assign ctrl.word = i_in.word_in;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_last
            assign nxt_word[g] = '0;
        end else begin : g_mid
            assign nxt_word[g] = cell_word[g + 1];
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_row
        ilwe_cell #(
            .IDX  (g),
            .CMPW (CMPW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_count     (cnt_x),
            .i_pos       (pos_x),
            .i_next_word (nxt_word[g]),
            .o_word      (cell_word[g]),
            .o_rd_word   (rd_word[g])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_or = rd_or | rd_word[k];
        end
    end

    always_comb begin
        n_count        = r_count;
        n_out.word_out = '0;
        n_out.status   = ST_OK;
        unique case (i_in.cmd)
            CMD_APPEND: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_DROP: begin
                if (r_count != '0) begin
                    n_count = r_count - CW'(1);
                end
            end
            CMD_ERASE: begin
                if (!hit) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            CMD_READ: begin
                if (!hit) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.word_out = rd_or;
                end
            end
            CMD_WRITE: begin
                if (!hit) begin
                    n_out.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        n_out.count = CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    `CHK_NEXT(a_strobe_follows, accept, o_strobe, "accepted word gave no result")
    `CHK_NEXT(a_full_holds, accept && (i_in.cmd == CMD_APPEND) && full,
        (o_out.status == ST_FULL) && $stable(r_count), "append on full list changed state")
    `CHK_ALWAYS(a_count_match, !o_strobe || (o_out.count == CNT_W'(r_count)),
        "reported count differs from held count")
    `CHK_ALWAYS(a_read_ok, !o_strobe || (o_out.word_out == '0) || (o_out.status == ST_OK),
        "nonzero word with error status")

endmodule

@@ dv/tb_indexed_list_with_erase_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_list_with_erase_top
// Drives command words into the indexed list: a short directed opening on
// the empty and out-of-range cases, then random phases that fill,
// drain or mix the list. Every result word is checked against a shadow copy
// of the list that is updated as each command is accepted.
// ----------------------------------------------------------------------------
module tb_indexed_list_with_erase_top;
    import ilwe_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int N_RANDOM      = 1400;
    localparam int MAX_GAP       = 13;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 200;
    localparam int TIMEOUT_NS    = 4_000_000;

    // Command codes the block decodes as no-ops.
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} t_phase_mode;

    class list_tracker;
        logic signed [WORD_W-1:0] shadow_words [DEPTH_DEF];
        int unsigned              n_words;
        t_out_word                pending_results [$];
        int unsigned              n_errors;
        int unsigned              n_noted;
        int unsigned              n_checked;
        int unsigned              n_full;
        int unsigned              n_range;
        int unsigned              peak_words;

        function new();
            foreach (shadow_words[k]) shadow_words[k] = '0;
            n_words    = 0;
            n_errors   = 0;
            n_noted    = 0;
            n_checked  = 0;
            n_full     = 0;
            n_range    = 0;
            peak_words = 0;
        endfunction

        task report(string msg);
            n_errors++;
            $display("%0t ERROR: %s", $time, msg);
        endtask

        // Applies one accepted command to the shadow list and queues the
        // result word it must produce.
        function void note_command(t_in_word w);
            t_out_word   exp;
            int unsigned idx;
            int unsigned k;
            bit          hit;
            idx = w.position;
            hit = idx < n_words;
            exp.word_out = '0;
            exp.status   = ST_OK;
            case (w.cmd)
                CMD_APPEND: begin
                    if (n_words >= DEPTH_DEF) begin
                        exp.status = ST_FULL;
                    end else begin
                        shadow_words[n_words] = w.word_in;
                        n_words++;
                    end
                end
                CMD_DROP: begin
                    if (n_words > 0) n_words--;
                end
                CMD_ERASE: begin
                    if (!hit) begin
                        exp.status = ST_RANGE;
                    end else begin
                        for (k = idx; k + 1 < n_words; k++)
                            shadow_words[k] = shadow_words[k + 1];
                        n_words--;
                    end
                end
                CMD_READ: begin
                    if (!hit) exp.status = ST_RANGE;
                    else exp.word_out = shadow_words[idx];
                end
                CMD_WRITE: begin
                    if (!hit) exp.status = ST_RANGE;
                    else shadow_words[idx] = w.word_in;
                end
                default: ;
            endcase
            exp.count = CNT_W'(n_words);
            if (exp.status == ST_FULL) n_full++;
            if (exp.status == ST_RANGE) n_range++;
            if (n_words > peak_words) peak_words = n_words;
            n_noted++;
            pending_results = {pending_results, exp};
        endfunction

        task check_result(t_out_word got);
            t_out_word exp;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result word: data %h status %0d count %0d",
                                 got.word_out, got.status, got.count));
                return;
            end
            exp = pending_results.pop_front();
            n_checked++;
            if (got.word_out !== exp.word_out)
                report($sformatf("result %0d word_out %h, expected %h",
                                 n_checked, got.word_out, exp.word_out));
            if (got.status !== exp.status)
                report($sformatf("result %0d status %0d, expected %0d",
                                 n_checked, got.status, exp.status));
            if (got.count !== exp.count)
                report($sformatf("result %0d count %0d, expected %0d",
                                 n_checked, got.count, exp.count));
        endtask
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_word  i_in    = '0;
    logic      o_strobe;
    t_out_word o_out;

    list_tracker tracker;
    bit          gaps_on = 1'b1;

    indexed_list_with_erase_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) tracker.check_result(o_out);
    end

    // Holds the command word until the block takes it; start stays high
    // across back-to-back words.
    task automatic send_word(t_cmd c, int unsigned pos, logic [WORD_W-1:0] val);
        t_in_word    w;
        int unsigned gap;
        w.cmd      = c;
        w.position = POS_W'(pos);
        w.word_in  = val;
        gap = gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= w;
        do @(posedge i_clk); while (busy);
        tracker.note_command(w);
    endtask

    function automatic t_cmd pick_cmd(t_phase_mode mode);
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 3) return t_cmd'(3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)));
        case (mode)
            MODE_FILL: begin
                if (roll < 70) return CMD_APPEND;
                if (roll < 76) return CMD_DROP;
                if (roll < 82) return CMD_ERASE;
                if (roll < 91) return CMD_READ;
                return CMD_WRITE;
            end
            MODE_DRAIN: begin
                if (roll < 25) return CMD_APPEND;
                if (roll < 50) return CMD_DROP;
                if (roll < 75) return CMD_ERASE;
                if (roll < 87) return CMD_READ;
                return CMD_WRITE;
            end
            default: begin
                if (roll < 30) return CMD_APPEND;
                if (roll < 42) return CMD_DROP;
                if (roll < 55) return CMD_ERASE;
                if (roll < 78) return CMD_READ;
                return CMD_WRITE;
            end
        endcase
    endfunction

    // Mostly a live index, sometimes anything the field can hold.
    function automatic int unsigned pick_position();
        if (tracker.n_words > 0 && $urandom_range(99, 0) < 80)
            return $urandom_range(tracker.n_words - 1, 0);
        return $urandom_range(63, 0);
    endfunction

    task automatic run_directed();
        send_word(CMD_READ, 0, 32'h0);
        send_word(CMD_DROP, 0, 32'h0);
        send_word(CMD_ERASE, 0, 32'h0);
        send_word(CMD_WRITE, 63, 32'hFFFF_FFFF);
        send_word(CMD_APPEND, 0, 32'h7FFF_FFFF);
        send_word(CMD_APPEND, 0, 32'h8000_0000);
        send_word(CMD_APPEND, 0, 32'h0000_0000);
        send_word(CMD_APPEND, 0, 32'hFFFF_FFFF);
        send_word(CMD_APPEND, 0, 32'h5A5A_A5A5);
        for (int k = 0; k < 5; k++) send_word(CMD_READ, k, 32'h0);
        send_word(CMD_WRITE, 1, 32'h1234_5678);
        send_word(CMD_READ, 1, 32'h0);
        send_word(CMD_ERASE, 1, 32'h0);
        send_word(CMD_ERASE, 3, 32'h0);
        send_word(CMD_READ, 63, 32'h0);
        send_word(t_cmd'(CMD_UNUSED_FIRST), 0, 32'hFFFF_FFFF);
        send_word(t_cmd'(CMD_UNUSED_MID), 63, 32'h0);
        send_word(t_cmd'(CMD_UNUSED_LAST), 1, 32'h1);
        send_word(CMD_READ, 0, 32'h0);
        send_word(CMD_DROP, 0, 32'h0);
    endtask

    initial begin
        t_phase_mode mode;
        int unsigned n_sent;
        int unsigned phase_len;
        int unsigned waited;
        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();

        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            mode      = t_phase_mode'($urandom_range(2, 0));
            phase_len = $urandom_range(120, 40);
            gaps_on   = $urandom_range(2, 0) != 0;
            repeat (phase_len) begin
                send_word(pick_cmd(mode), pick_position(), $urandom);
                n_sent++;
            end
        end
        start <= 1'b0;

        waited = 0;
        while (tracker.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (tracker.pending_results.size() != 0)
            tracker.report($sformatf("%0d result words never arrived",
                                     tracker.pending_results.size()));
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands, checked %0d result words.",
                 tracker.n_noted, tracker.n_checked);
        $display("Saw %0d appends to a full list, %0d bad indexes, peak count %0d.",
                 tracker.n_full, tracker.n_range, tracker.peak_words);
        if (tracker.n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("Timed out waiting on the block.");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ indexed_list_with_erase_top.f @@
+incdir+hdl
hdl/ilwe_pkg.sv
hdl/ilwe_cell.sv
hdl/indexed_list_with_erase_top.sv
dv/tb_indexed_list_with_erase_top.sv
